// ----- rtl/core/assert_macros.svh -----
// Assertion helper macros for the pose frame deframer.
// Clocked concurrent assertions with an active-low reset that disables them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/core/pfd_pkg.sv -----
// Shared constants, types and helpers for the pose frame deframer.
// No dependencies; used by every module of the block.
`default_nettype none

package pfd_pkg;

    localparam int FRAME_LENGTH      = 28;
    localparam int ADDR_W            = $clog2(FRAME_LENGTH);
    localparam int NUM_WORDS         = 6;
    localparam int WORD_W            = 32;
    localparam int CNT_W             = 32;
    localparam int PAYLOAD_FIRST_REL = 2;
    localparam int PAYLOAD_LAST_REL  = PAYLOAD_FIRST_REL + 4 * NUM_WORDS - 1;
    localparam int REL_TOP           = (FRAME_LENGTH > PAYLOAD_LAST_REL + 1) ?
                                       FRAME_LENGTH : PAYLOAD_LAST_REL + 1;
    localparam int REL_W             = $clog2(REL_TOP + 1);

    localparam logic [7:0] HDR0 = 8'h0D;
    localparam logic [7:0] HDR1 = 8'h0A;
    localparam logic [7:0] TL0  = 8'h0A;
    localparam logic [7:0] TL1  = 8'h0D;

    localparam int          AGE_W         = 20;
    localparam logic [19:0] AGE_MAX       = 20'hFFFFF;
    localparam logic [19:0] TIMEOUT_RESET = 20'd500;

    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef logic [NUM_WORDS*WORD_W-1:0] frame_words_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic fire;
        logic tick;
        logic frame_done;
        logic frame_ok;
    } parse_evt_t;

    typedef struct packed {
        frame_words_t     words;
        logic [CNT_W-1:0] frame_count;
        logic [CNT_W-1:0] bad_frame_count;
        logic             connected;
        logic             recent_frame;
    } status_t;

    typedef struct packed {
        logic        frame_done;
        logic        frame_valid;
        logic [31:0] yaw_bits;
        logic [31:0] pitch_bits;
        logic [31:0] roll_bits;
        logic [31:0] pos_x_bits;
        logic [31:0] pos_y_bits;
        logic [31:0] omega_z_bits;
        logic [31:0] frame_count;
        logic [31:0] bad_frame_count;
        logic        connected;
        logic        recent_frame;
    } result_t;

    // Circular buffer index add, both operands below FRAME_LENGTH.
    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (ADDR_W+1)'(FRAME_LENGTH))
            s = s - (ADDR_W+1)'(FRAME_LENGTH);
        return s[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pfd_byte_ram.sv -----
// Frame byte store: one write port, one read port, registered read data.
// Depends on pfd_pkg for depth and address width.
`default_nettype none

module pfd_byte_ram (
    input  wire logic                      clk,
    input  wire logic                      wr_en,
    input  wire logic [pfd_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [7:0]                wr_data,
    input  wire logic [pfd_pkg::ADDR_W-1:0] rd_addr,
    output      logic [7:0]                rd_data
);

    logic [7:0] mem [pfd_pkg::FRAME_LENGTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pfd_parser.sv -----
// Frame sequencer: circular byte buffer in pfd_byte_ram, header rescan
// after a bad tail, and payload readout. Depends on pfd_pkg, pfd_byte_ram.
`default_nettype none

module pfd_parser (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire pfd_pkg::item_t        item,
    output      pfd_pkg::parse_evt_t   evt,
    output      pfd_pkg::frame_words_t words
);

    localparam int AW = pfd_pkg::ADDR_W;
    localparam int RW = pfd_pkg::REL_W;
    localparam int WW = pfd_pkg::NUM_WORDS * pfd_pkg::WORD_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_READ, ST_FINISH} state_t;

    state_t                state_reg;
    logic [AW-1:0]         head_reg;
    logic [AW-1:0]         fill_reg;
    logic [RW-1:0]         iss_reg;
    logic                  pend_reg;
    logic [RW-1:0]         pend_rel_reg;
    logic                  pend_zero_reg;
    logic                  scan_first_reg;
    logic [7:0]            scan_prev_reg;
    logic [7:0]            last_byte_reg;
    pfd_pkg::frame_words_t words_reg;
    pfd_pkg::parse_evt_t   evt_reg;

    logic [AW-1:0] wr_pos;
    logic [AW-1:0] rd_pos;
    logic [7:0]    rd_data;
    logic          ram_we;
    logic          issue_scan;
    logic          issue_read;
    logic          hdr_hit;
    logic [RW-1:0] hdr_rel;
    logic [AW-1:0] fill_after_hdr;
    logic          frame_ok;
    logic          byte_in;

    assign byte_in        = start && (item.command == pfd_pkg::CMD_BYTE);
    assign wr_pos         = pfd_pkg::wrap_add(head_reg, fill_reg);
    assign rd_pos         = pfd_pkg::wrap_add(head_reg, iss_reg[AW-1:0]);
    assign ram_we         = (state_reg == ST_IDLE) && byte_in;
    assign issue_scan     = iss_reg <= RW'(pfd_pkg::FRAME_LENGTH - 1);
    assign issue_read     = iss_reg <= RW'(pfd_pkg::PAYLOAD_LAST_REL);
    assign hdr_hit        = !scan_first_reg && (scan_prev_reg == pfd_pkg::HDR0)
                            && (rd_data == pfd_pkg::HDR1);
    assign hdr_rel        = pend_rel_reg - RW'(1);
    assign fill_after_hdr = AW'((AW+1)'(pfd_pkg::FRAME_LENGTH) - (AW+1)'(hdr_rel));

    // A word is finite unless its exponent is all ones.
    always_comb
    begin
        frame_ok = 1'b1;
        for (int i = 0; i < pfd_pkg::NUM_WORDS; i++)
        begin
            if (&words_reg[i*pfd_pkg::WORD_W+23 +: 8])
                frame_ok = 1'b0;
        end
    end

    pfd_byte_ram u_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (wr_pos),
        .wr_data (item.data_byte),
        .rd_addr (rd_pos),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            fill_reg       <= '0;
            iss_reg        <= '0;
            pend_reg       <= 1'b0;
            pend_rel_reg   <= '0;
            pend_zero_reg  <= 1'b0;
            scan_first_reg <= 1'b1;
            evt_reg        <= '0;
        end
        else
        begin
            evt_reg <= '0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (start && (item.command == pfd_pkg::CMD_TICK))
                    begin
                        evt_reg.fire <= 1'b1;
                        evt_reg.tick <= 1'b1;
                    end
                    else if (byte_in)
                    begin
                        if (fill_reg == '0)
                        begin
                            fill_reg     <= AW'(1);
                            evt_reg.fire <= 1'b1;
                        end
                        else if (fill_reg == AW'(1))
                        begin
                            // lone byte: either it starts a header or the new byte replaces it
                            if ((last_byte_reg == pfd_pkg::HDR0) &&
                                (item.data_byte == pfd_pkg::HDR1))
                                fill_reg <= AW'(2);
                            else
                                head_reg <= wr_pos;
                            evt_reg.fire <= 1'b1;
                        end
                        else if (fill_reg != AW'(pfd_pkg::FRAME_LENGTH - 1))
                        begin
                            fill_reg     <= fill_reg + AW'(1);
                            evt_reg.fire <= 1'b1;
                        end
                        else
                        begin
                            iss_reg        <= RW'(pfd_pkg::PAYLOAD_FIRST_REL);
                            pend_reg       <= 1'b0;
                            scan_first_reg <= 1'b1;
                            if ((last_byte_reg == pfd_pkg::TL0) &&
                                (item.data_byte == pfd_pkg::TL1))
                                state_reg <= ST_READ;
                            else
                                state_reg <= ST_SCAN;
                        end
                    end
                end

                ST_SCAN:
                begin
                    if (issue_scan)
                    begin
                        iss_reg      <= iss_reg + RW'(1);
                        pend_reg     <= 1'b1;
                        pend_rel_reg <= iss_reg;
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg)
                    begin
                        scan_first_reg <= 1'b0;
                        if (hdr_hit)
                        begin
                            head_reg     <= pfd_pkg::wrap_add(head_reg, hdr_rel[AW-1:0]);
                            fill_reg     <= fill_after_hdr;
                            evt_reg.fire <= 1'b1;
                            pend_reg     <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                        else if (pend_rel_reg == RW'(pfd_pkg::FRAME_LENGTH - 1))
                        begin
                            // no header left: keep only the newest byte
                            head_reg     <= pfd_pkg::wrap_add(head_reg,
                                                AW'(pfd_pkg::FRAME_LENGTH - 1));
                            fill_reg     <= AW'(1);
                            evt_reg.fire <= 1'b1;
                            pend_reg     <= 1'b0;
                            state_reg    <= ST_IDLE;
                        end
                    end
                end

                ST_READ:
                begin
                    if (issue_read)
                    begin
                        iss_reg       <= iss_reg + RW'(1);
                        pend_reg      <= 1'b1;
                        pend_rel_reg  <= iss_reg;
                        pend_zero_reg <= iss_reg >= RW'(pfd_pkg::FRAME_LENGTH);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                    end
                    if (pend_reg && (pend_rel_reg == RW'(pfd_pkg::PAYLOAD_LAST_REL)))
                    begin
                        pend_reg  <= 1'b0;
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    fill_reg           <= '0;
                    evt_reg.fire       <= 1'b1;
                    evt_reg.frame_done <= 1'b1;
                    evt_reg.frame_ok   <= frame_ok;
                    state_reg          <= ST_IDLE;
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // payload: last byte seen, scan history, payload shift line (byte 0 ends lowest)
    always_ff @(posedge clk)
    begin
        if (ram_we)
            last_byte_reg <= item.data_byte;
        if ((state_reg == ST_SCAN) && pend_reg)
            scan_prev_reg <= rd_data;
        if ((state_reg == ST_READ) && pend_reg)
            words_reg <= {(pend_zero_reg ? 8'h00 : rd_data), words_reg[WW-1:8]};
    end

    assign evt   = evt_reg;
    assign words = words_reg;

endmodule

`default_nettype wire

// ----- rtl/core/pfd_status.sv -----
// Held pose words, frame counters, link ages and the timeout register.
// Depends on pfd_pkg; fed by parse events from pfd_parser.
`default_nettype none

module pfd_status (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pfd_pkg::parse_evt_t    evt,
    input  wire pfd_pkg::frame_words_t  words,
    input  wire logic                   cfg_wr_en,
    input  wire logic [pfd_pkg::AGE_W-1:0] cfg_wr_data,
    output      pfd_pkg::status_t       status
);

    pfd_pkg::frame_words_t       held_reg;
    logic [pfd_pkg::CNT_W-1:0]   seen_reg;
    logic [pfd_pkg::CNT_W-1:0]   bad_reg;
    logic [pfd_pkg::AGE_W-1:0]   age_valid_reg;
    logic [pfd_pkg::AGE_W-1:0]   age_frame_reg;
    logic                        valid_ever_reg;
    logic                        frame_ever_reg;
    logic [pfd_pkg::AGE_W-1:0]   timeout_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg       <= '0;
            seen_reg       <= '0;
            bad_reg        <= '0;
            age_valid_reg  <= '0;
            age_frame_reg  <= '0;
            valid_ever_reg <= 1'b0;
            frame_ever_reg <= 1'b0;
            timeout_reg    <= pfd_pkg::TIMEOUT_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                timeout_reg <= cfg_wr_data;
            if (evt.fire && evt.tick)
            begin
                if (age_valid_reg != pfd_pkg::AGE_MAX)
                    age_valid_reg <= age_valid_reg + pfd_pkg::AGE_W'(1);
                if (age_frame_reg != pfd_pkg::AGE_MAX)
                    age_frame_reg <= age_frame_reg + pfd_pkg::AGE_W'(1);
            end
            if (evt.fire && evt.frame_done)
            begin
                seen_reg       <= seen_reg + pfd_pkg::CNT_W'(1);
                frame_ever_reg <= 1'b1;
                age_frame_reg  <= '0;
                if (evt.frame_ok)
                begin
                    held_reg       <= words;
                    valid_ever_reg <= 1'b1;
                    age_valid_reg  <= '0;
                end
                else
                begin
                    bad_reg <= bad_reg + pfd_pkg::CNT_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        status.words           = held_reg;
        status.frame_count     = seen_reg;
        status.bad_frame_count = bad_reg;
        status.connected       = valid_ever_reg && (age_valid_reg < timeout_reg);
        status.recent_frame    = frame_ever_reg && (age_frame_reg < timeout_reg);
    end

endmodule

`default_nettype wire

// ----- rtl/core/pose_frame_deframer.sv -----
// Ticks and ordinary bytes go from accept through the parser event register and pend_reg
// into the result register; a bad tail rescans the buffer RAM one byte a cycle; a good
// tail reads 24 payload bytes from the RAM. One item in flight; the next is taken the
// cycle after its result is loaded, and loading waits while a held result is not taken.
// Reset clears fill, counters, ages, flags, timeout to 500; buffer RAM left as is.
// Depends on pfd_pkg, pfd_parser, pfd_status.
`default_nettype none

`include "assert_macros.svh"

module pose_frame_deframer (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      item_valid,
    output      logic                      item_ready,
    input  wire pfd_pkg::item_t            item,
    output      logic                      result_valid,
    input  wire logic                      result_ready,
    output      pfd_pkg::result_t          result,
    input  wire logic                      cfg_wr_en,
    input  wire logic [pfd_pkg::AGE_W-1:0] cfg_wr_data
);

    pfd_pkg::parse_evt_t   evt;
    pfd_pkg::frame_words_t words;
    pfd_pkg::status_t      status;

    logic             busy_reg;
    logic             pend_reg;
    logic             done_reg;
    logic             ok_reg;
    logic             result_valid_reg;
    pfd_pkg::result_t result_reg;
    pfd_pkg::result_t result_next;
    logic             start;
    logic             load;

    assign item_ready = !busy_reg;
    assign start      = item_valid && item_ready;
    assign load       = pend_reg && (!result_valid_reg || result_ready);

    pfd_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .item  (item),
        .evt   (evt),
        .words (words)
    );

    pfd_status u_status (
        .clk         (clk),
        .rst_n       (rst_n),
        .evt         (evt),
        .words       (words),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .status      (status)
    );

    always_comb
    begin
        result_next.frame_done      = done_reg;
        result_next.frame_valid     = ok_reg;
        result_next.yaw_bits        = status.words[0*32 +: 32];
        result_next.pitch_bits      = status.words[1*32 +: 32];
        result_next.roll_bits       = status.words[2*32 +: 32];
        result_next.pos_x_bits      = status.words[3*32 +: 32];
        result_next.pos_y_bits      = status.words[4*32 +: 32];
        result_next.omega_z_bits    = status.words[5*32 +: 32];
        result_next.frame_count     = status.frame_count;
        result_next.bad_frame_count = status.bad_frame_count;
        result_next.connected       = status.connected;
        result_next.recent_frame    = status.recent_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (start)
                busy_reg <= 1'b1;
            if (evt.fire)
                pend_reg <= 1'b1;
            if (load)
            begin
                pend_reg         <= 1'b0;
                busy_reg         <= 1'b0;
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // status snapshot is stable from the event until the beat is loaded
    always_ff @(posedge clk)
    begin
        if (evt.fire)
        begin
            done_reg <= evt.frame_done;
            ok_reg   <= evt.frame_ok;
        end
        if (load)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `ASSERT_NEXT(a_accept_blocks, clk, rst_n, item_valid && item_ready, !item_ready)
    `ASSERT_IMPLIES(a_evt_in_item, clk, rst_n, evt.fire, busy_reg && !pend_reg)
    `ASSERT_IMPLIES(a_pend_busy, clk, rst_n, pend_reg, busy_reg)

endmodule

`default_nettype wire
